FILE: rtl/core/cmdl_pkg.sv
// Shared types, character codes and the per-character parse step of the command line decoder.
`timescale 1ns / 1ps

package cmdl_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam logic [6:0] DUTY_CAP = 7'd100;
   localparam logic [2:0] POS_LAST = 3'd7;

   // candidate flag bits
   localparam int FLAG_STOP   = 0;
   localparam int FLAG_ENCALL = 1;
   localparam int FLAG_ENC    = 2;
   localparam int FLAG_MOTOR  = 3;

   localparam logic [2:0] POS_KEY0 = 3'd0;
   localparam logic [2:0] POS_KEY1 = 3'd1;
   localparam logic [2:0] POS_KEY2 = 3'd2;
   localparam logic [2:0] POS_KEY3 = 3'd3;
   localparam logic [2:0] POS_KEY4 = 3'd4;
   localparam logic [2:0] POS_KEY5 = 3'd5;

   localparam logic [2:0] KIND_STOP_ALL = 3'd0;
   localparam logic [2:0] KIND_READ_ALL = 3'd1;
   localparam logic [2:0] KIND_READ_ONE = 3'd2;
   localparam logic [2:0] KIND_SET_DUTY = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   typedef struct packed {
      logic       skipping_blanks;
      logic [2:0] char_position;
      logic [3:0] candidate_flags;
      logic [1:0] held_motor;
      logic       negative_sign;
      logic [6:0] duty_accumulator;
      logic       digits_open;
      logic       text_closed;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]        command_kind;
      logic [1:0]        motor_index;
      logic signed [7:0] duty_value;
   } result_type;

   localparam parse_state_type PARSE_RESET = '{
      skipping_blanks:  1'b1,
      char_position:    3'd0,
      candidate_flags:  4'hF,
      held_motor:       2'd0,
      negative_sign:    1'b0,
      duty_accumulator: 7'd0,
      digits_open:      1'b1,
      text_closed:      1'b0
   };

   function automatic logic letter_is(logic [7:0] c, logic [7:0] upper);
      return (c == upper) || (c == (upper + CASE_GAP));
   endfunction

   function automatic logic motor_digit(logic [7:0] c);
      return (c >= CHAR_ONE) && (c <= CHAR_FOUR);
   endfunction

   // One character through the keyword matcher and duty accumulator.
   function automatic parse_state_type take_char(parse_state_type s, logic [7:0] c);
      parse_state_type n;
      logic [7:0]      motor_off;
      logic [9:0]      acc_ext;
      logic [9:0]      acc_next;
      n         = s;
      motor_off = c - CHAR_ONE;
      acc_ext   = {3'b000, s.duty_accumulator};
      acc_next  = (acc_ext << 3) + (acc_ext << 1) + {6'b000000, c[3:0]};
      if (s.skipping_blanks && ((c == CHAR_SPACE) || (c == CHAR_TAB))) begin
         return s;
      end
      n.skipping_blanks = 1'b0;
      case (s.char_position)
         POS_KEY0: begin
            if (!letter_is(c, "S")) n.candidate_flags[FLAG_STOP] = 1'b0;
            if (!letter_is(c, "E")) begin
               n.candidate_flags[FLAG_ENCALL] = 1'b0;
               n.candidate_flags[FLAG_ENC]    = 1'b0;
            end
            if (!letter_is(c, "M")) n.candidate_flags[FLAG_MOTOR] = 1'b0;
         end
         POS_KEY1: begin
            if (!letter_is(c, "T")) n.candidate_flags[FLAG_STOP] = 1'b0;
            if (!letter_is(c, "N")) begin
               n.candidate_flags[FLAG_ENCALL] = 1'b0;
               n.candidate_flags[FLAG_ENC]    = 1'b0;
            end
            if (!motor_digit(c)) n.candidate_flags[FLAG_MOTOR] = 1'b0;
            if (n.candidate_flags[FLAG_MOTOR]) n.held_motor = motor_off[1:0];
         end
         POS_KEY2: begin
            if (!letter_is(c, "O")) n.candidate_flags[FLAG_STOP] = 1'b0;
            if (!letter_is(c, "C")) begin
               n.candidate_flags[FLAG_ENCALL] = 1'b0;
               n.candidate_flags[FLAG_ENC]    = 1'b0;
            end
            if (!((c == CHAR_PLUS) || (c == CHAR_MINUS)))
               n.candidate_flags[FLAG_MOTOR] = 1'b0;
            n.negative_sign = (c == CHAR_MINUS);
         end
         POS_KEY3: begin
            if (!letter_is(c, "P")) n.candidate_flags[FLAG_STOP] = 1'b0;
            if (!letter_is(c, "A")) n.candidate_flags[FLAG_ENCALL] = 1'b0;
            if (!motor_digit(c)) n.candidate_flags[FLAG_ENC] = 1'b0;
            if (n.candidate_flags[FLAG_ENC]) n.held_motor = motor_off[1:0];
         end
         POS_KEY4: begin
            if (!((c == CHAR_NUL) || (c == CHAR_CR) || (c == CHAR_LF) ||
                  (c == CHAR_SPACE)))
               n.candidate_flags[FLAG_STOP] = 1'b0;
            if (!letter_is(c, "L")) n.candidate_flags[FLAG_ENCALL] = 1'b0;
         end
         POS_KEY5: begin
            if (!letter_is(c, "L")) n.candidate_flags[FLAG_ENCALL] = 1'b0;
         end
         default: begin
         end
      endcase
      if ((s.char_position >= POS_KEY3) && s.digits_open) begin
         if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            n.duty_accumulator = (acc_next > {3'b000, DUTY_CAP}) ? DUTY_CAP : acc_next[6:0];
         end else begin
            n.digits_open = 1'b0;
         end
      end
      if (s.char_position != POS_LAST) n.char_position = s.char_position + 3'd1;
      return n;
   endfunction

endpackage

FILE: rtl/core/cmdl_parser.sv
// Line parse state and the per-character update; emits the decoded result on a line's last character.
`timescale 1ns / 1ps

module cmdl_parser
   import cmdl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] char_code,
   input  logic       line_end,
   output logic       result_valid,
   output result_type result
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type after_char;
   parse_state_type after_end;
   logic [7:0]      duty_mag;

   always_comb begin
      after_char = state_ff;
      if (!state_ff.text_closed) begin
         after_char = take_char(state_ff, char_code);
         if (char_code == CHAR_NUL) after_char.text_closed = 1'b1;
      end
      // line end behaves as a trailing NUL unless one already closed the text
      after_end = after_char;
      if (!after_char.text_closed) after_end = take_char(after_char, CHAR_NUL);

      state_in = state_ff;
      if (take) state_in = line_end ? PARSE_RESET : after_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign duty_mag = {1'b0, after_end.duty_accumulator};

   always_comb begin
      result.command_kind = KIND_ERROR;
      result.motor_index  = 2'd0;
      result.duty_value   = 8'sd0;
      if (after_end.candidate_flags[FLAG_STOP]) begin
         result.command_kind = KIND_STOP_ALL;
      end else if (after_end.candidate_flags[FLAG_ENCALL]) begin
         result.command_kind = KIND_READ_ALL;
      end else if (after_end.candidate_flags[FLAG_ENC]) begin
         result.command_kind = KIND_READ_ONE;
         result.motor_index  = after_end.held_motor;
      end else if (after_end.candidate_flags[FLAG_MOTOR]) begin
         result.command_kind = KIND_SET_DUTY;
         result.motor_index  = after_end.held_motor;
         result.duty_value   = after_end.negative_sign ? $signed(8'd0 - duty_mag)
                                                       : $signed(duty_mag);
      end
   end

   assign result_valid = take && line_end;

endmodule

FILE: rtl/core/cmdl_rsp_reg.sv
// Result register on the rsp channel; holds one decoded transaction while stalled.
`timescale 1ns / 1ps

module cmdl_rsp_reg
   import cmdl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       full,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign full      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/motor_command_line_decoder_core.sv
// Top level of the motor command line decoder: parser plus registered result port.
`timescale 1ns / 1ps

// Takes one character of a command line per cycle on req_ while req_stall is low
// and gives one decoded command on rsp_ for every line, registered in the cycle
// after the transaction that carries req_line_end. Leading blanks are skipped and
// keywords are case blind: STOP, ENCALL, ENC<1-4>, M<1-4><+|-><digits> (duty capped
// at 100), else error. The parse state is a single register updated per character.
// req_stall rises only while a finished result sits in the output register and
// rsp_stall is high, so with a free downstream a new line may start right away.

module motor_command_line_decoder_core
   import cmdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_char_code,
   input  logic              req_line_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_command_kind,
   output logic [1:0]        rsp_motor_index,
   output logic signed [7:0] rsp_duty_value
);

   logic       take;
   logic       result_valid;
   logic       out_full;
   result_type result;
   result_type rsp_data;

   assign req_stall = out_full;
   assign take      = req_valid && !out_full;

   cmdl_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_char_code),
      .line_end     (req_line_end),
      .result_valid (result_valid),
      .result       (result)
   );

   cmdl_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_command_kind = rsp_data.command_kind;
   assign rsp_motor_index  = rsp_data.motor_index;
   assign rsp_duty_value   = rsp_data.duty_value;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   a_duty_only_for_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_command_kind != KIND_SET_DUTY)) |-> (rsp_duty_value == 8'sd0))
      else $error("nonzero duty on a non set-duty command");

   a_motor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_command_kind == KIND_STOP_ALL) ||
                     (rsp_command_kind == KIND_READ_ALL) ||
                     (rsp_command_kind == KIND_ERROR))) |-> (rsp_motor_index == 2'd0))
      else $error("motor index set on a command without a motor");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_duty_value <= 8'sd100) && (rsp_duty_value >= -8'sd100)))
      else $error("duty outside -100..100");

   a_line_end_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_line_end) |=> rsp_valid)
      else $error("line end transaction produced no result");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the motor command line decoder core.
`timescale 1ns / 1ps

module tb;
   import cmdl_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_CHARS   = 600;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } line_char_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_char_code = 8'd0;
   logic              req_line_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_command_kind;
   logic [1:0]        rsp_motor_index;
   logic signed [7:0] rsp_duty_value;

   motor_command_line_decoder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_kind (rsp_command_kind),
      .rsp_motor_index  (rsp_motor_index),
      .rsp_duty_value   (rsp_duty_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   line_char_type char_backlog[$];
   logic [7:0] line_buf[$];
   result_type pending_cmds[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         mismatch_count = 0;
   int         results_seen = 0;
   int         cycle_count = 0;

   // decoder shadow state
   logic       in_blanks;
   logic [2:0] col;
   logic [3:0] alive;
   logic [1:0] motor_sel;
   logic       minus;
   logic [6:0] duty_acc;
   logic       dig_open;
   logic       text_done;

   function automatic logic ci_eq(logic [7:0] c, logic [7:0] up);
      return (c == up) || (c == (up | 8'h20));
   endfunction

   function automatic logic is_motor_digit(logic [7:0] c);
      return (c >= CHAR_ONE) && (c <= CHAR_FOUR);
   endfunction

   task automatic clear_decoder();
      in_blanks = 1'b1;
      col       = 3'd0;
      alive     = 4'hF;
      motor_sel = 2'd0;
      minus     = 1'b0;
      duty_acc  = 7'd0;
      dig_open  = 1'b1;
      text_done = 1'b0;
   endtask

   task automatic scan_char(logic [7:0] c);
      int         v;
      logic [7:0] off;
      off = c - CHAR_ONE;
      if (in_blanks && ((c == CHAR_SPACE) || (c == CHAR_TAB))) return;
      in_blanks = 1'b0;
      case (col)
         3'd0: begin
            if (!ci_eq(c, "S")) alive[FLAG_STOP] = 1'b0;
            if (!ci_eq(c, "E")) begin
               alive[FLAG_ENCALL] = 1'b0;
               alive[FLAG_ENC]    = 1'b0;
            end
            if (!ci_eq(c, "M")) alive[FLAG_MOTOR] = 1'b0;
         end
         3'd1: begin
            if (!ci_eq(c, "T")) alive[FLAG_STOP] = 1'b0;
            if (!ci_eq(c, "N")) begin
               alive[FLAG_ENCALL] = 1'b0;
               alive[FLAG_ENC]    = 1'b0;
            end
            if (!is_motor_digit(c)) alive[FLAG_MOTOR] = 1'b0;
            if (alive[FLAG_MOTOR]) motor_sel = off[1:0];
         end
         3'd2: begin
            if (!ci_eq(c, "O")) alive[FLAG_STOP] = 1'b0;
            if (!ci_eq(c, "C")) begin
               alive[FLAG_ENCALL] = 1'b0;
               alive[FLAG_ENC]    = 1'b0;
            end
            if ((c != CHAR_PLUS) && (c != CHAR_MINUS)) alive[FLAG_MOTOR] = 1'b0;
            minus = (c == CHAR_MINUS);
         end
         3'd3: begin
            if (!ci_eq(c, "P")) alive[FLAG_STOP] = 1'b0;
            if (!ci_eq(c, "A")) alive[FLAG_ENCALL] = 1'b0;
            if (!is_motor_digit(c)) alive[FLAG_ENC] = 1'b0;
            if (alive[FLAG_ENC]) motor_sel = off[1:0];
         end
         3'd4: begin
            if (!((c == CHAR_NUL) || (c == CHAR_CR) || (c == CHAR_LF) ||
                  (c == CHAR_SPACE)))
               alive[FLAG_STOP] = 1'b0;
            if (!ci_eq(c, "L")) alive[FLAG_ENCALL] = 1'b0;
         end
         3'd5: begin
            if (!ci_eq(c, "L")) alive[FLAG_ENCALL] = 1'b0;
         end
         default: begin
         end
      endcase
      if ((col >= 3'd3) && dig_open) begin
         if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            v = int'(duty_acc) * 10 + int'(c - CHAR_ZERO);
            duty_acc = (v > 100) ? DUTY_CAP : v[6:0];
         end else begin
            dig_open = 1'b0;
         end
      end
      if (col != 3'd7) col = col + 3'd1;
   endtask

   // one accepted character; a line end queues the decoded command
   task automatic decode_accepted(logic [7:0] c, logic last);
      result_type r;
      if (!text_done) begin
         scan_char(c);
         if (c == CHAR_NUL) text_done = 1'b1;
      end
      if (!last) return;
      if (!text_done) scan_char(CHAR_NUL);
      r = '0;
      if (alive[FLAG_STOP]) begin
         r.command_kind = KIND_STOP_ALL;
      end else if (alive[FLAG_ENCALL]) begin
         r.command_kind = KIND_READ_ALL;
      end else if (alive[FLAG_ENC]) begin
         r.command_kind = KIND_READ_ONE;
         r.motor_index  = motor_sel;
      end else if (alive[FLAG_MOTOR]) begin
         r.command_kind = KIND_SET_DUTY;
         r.motor_index  = motor_sel;
         r.duty_value   = minus ? -$signed({1'b0, duty_acc}) : $signed({1'b0, duty_acc});
      end else begin
         r.command_kind = KIND_ERROR;
      end
      pending_cmds.push_back(r);
      clear_decoder();
   endtask

   // line assembly
   task automatic put_word(string w, bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < w.len(); i++) begin
         c = w[i];
         if (mix_case && (c >= "A") && (c <= "Z") && ($urandom_range(0, 1) == 1))
            c = c | 8'h20;
         line_buf.push_back(c);
      end
   endtask

   task automatic put_trailer();
      int n;
      n = $urandom_range(0, 3);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic flush_line(inout int added);
      line_char_type it;
      if (line_buf.size() == 0) line_buf.push_back(CHAR_SPACE);
      foreach (line_buf[i]) begin
         it.code = line_buf[i];
         it.last = (i == line_buf.size() - 1);
         char_backlog.push_back(it);
      end
      added += line_buf.size();
      line_buf.delete();
   endtask

   task automatic add_random_line(inout int added);
      int    pick;
      int    n;
      int    k;
      string w;
      n = $urandom_range(0, 3);
      repeat (n) line_buf.push_back(($urandom_range(0, 1) == 1) ? CHAR_SPACE : CHAR_TAB);
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            put_word("STOP", 1);
            case ($urandom_range(0, 5))
               0: ;
               1: line_buf.push_back(CHAR_CR);
               2: line_buf.push_back(CHAR_LF);
               3: line_buf.push_back(CHAR_SPACE);
               4: line_buf.push_back(CHAR_NUL);
               default: line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
            put_trailer();
         end
         2: begin
            put_word("ENCALL", 1);
            put_trailer();
         end
         3, 4: begin
            put_word("ENC", 1);
            line_buf.push_back(8'($urandom_range(8'h30, 8'h35)));
            put_trailer();
         end
         5, 6, 7: begin
            put_word("M", 1);
            line_buf.push_back(8'($urandom_range(8'h30, 8'h35)));
            k = $urandom_range(0, 9);
            line_buf.push_back((k < 4) ? CHAR_MINUS : (k < 9) ? CHAR_PLUS : 8'h2A);
            n = $urandom_range(0, 5);
            repeat (n) line_buf.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            if ($urandom_range(0, 1) == 1) put_trailer();
         end
         8: begin
            n = $urandom_range(1, 8);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: w = "STOP";
               1: w = "ENCALL";
               2: w = "ENC3";
               default: w = "M2+57";
            endcase
            k = $urandom_range(1, w.len() - 1);
            put_word(w.substr(0, k - 1), 1);
            line_buf.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      // occasional corruption of one character
      if ((line_buf.size() > 0) && ($urandom_range(0, 9) == 0))
         line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      flush_line(added);
   endtask

   task automatic add_directed_lines(inout int added);
      put_word("\tsToP", 0);        flush_line(added);
      put_word("STOP\rx", 0);       flush_line(added);
      put_word("M4-250", 0);        flush_line(added);
      put_word("m1+", 0);           flush_line(added);
      put_word("M2-0", 0);          flush_line(added);
      put_word("Enc4x", 0);         flush_line(added);
      put_word(" encALLz", 0);      flush_line(added);
      // NUL closes the text, the rest of the line is ignored
      put_word("E", 0);
      line_buf.push_back(CHAR_NUL);
      line_buf.push_back(8'hFF);
      flush_line(added);
      put_word(" ", 0);             flush_line(added);
      line_buf.push_back(8'hFF);    flush_line(added);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      line_char_type next_item;
      logic       next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            decode_accepted(req_char_code, req_line_end);
            next_valid = 1'b0;
         end
         if (!next_valid && (char_backlog.size() > 0) &&
             ($urandom_range(0, 99) >= send_idle_pct)) begin
            next_item = char_backlog.pop_front();
            next_valid = 1'b1;
            req_char_code <= next_item.code;
            req_line_end  <= next_item.last;
         end
         req_valid <= next_valid;
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // response monitor and receiver stall
   int hold_left = 0;

   always @(posedge clock) begin : watch_rsp
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_cmds.size() == 0) begin
               $display("%0t: unexpected command, actual kind %0d motor %0d duty %0d",
                        $time, rsp_command_kind, rsp_motor_index, rsp_duty_value);
               mismatch_count++;
            end else begin
               want = pending_cmds.pop_front();
               check_field("command_kind", want.command_kind, rsp_command_kind);
               check_field("motor_index", want.motor_index, rsp_motor_index);
               check_field("duty_value", $signed(want.duty_value), rsp_duty_value);
            end
            results_seen++;
            // long hold-off so the core backs up and stalls its input
            if ((results_seen % 90) == 40) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int send_pct[3];
      int recv_pct[3];
      int added;
      send_pct = '{14, 58, 0};
      recv_pct = '{58, 14, 0};
      clear_decoder();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = send_pct[ph];
         recv_idle_pct = recv_pct[ph];
         added = 0;
         if (ph == 0) add_directed_lines(added);
         while (added < PHASE_CHARS) add_random_line(added);
         while ((char_backlog.size() != 0) || req_valid || (pending_cmds.size() != 0))
            @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if ((mismatch_count == 0) && (pending_cmds.size() == 0)) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
